@@ src/assert_macros.svh @@
// assertion macros used by the rtl file priority_task_queue_with_cancel
// no dependencies; pulled in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/ptq_pkg.sv @@
// types and codes of the priority task queue
// no dependencies; imported by priority_task_queue_with_cancel
`default_nettype none

package ptq_pkg;

    // operation codes carried on the input tuser
    typedef enum logic [2:0] {
        FN_ADD        = 3'd0,
        FN_CANCEL     = 3'd1,
        FN_CANCEL_ALL = 3'd2,
        FN_EXTRACT    = 3'd3,
        FN_FINISH     = 3'd4
    } t_func;

    // status codes of a result word
    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_ZERO_ID = 2'd1,
        STS_FULL    = 2'd2,
        STS_EMPTY   = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_FIND = 2'd1,
        S_PACK = 2'd2,
        S_DONE = 2'd3
    } t_state;

    // width of the count fields in a result word
    localparam int CNT_OUT_W = 5;

endpackage

`default_nettype wire

@@ src/priority_task_queue_with_cancel.sv @@
// priority task queue with cancel by id: pending table, current slot, sequencer
// depends on ptq_pkg and assert_macros.svh
//
// One word in, one result word out. The pending table is a single-port-write,
// registered-read memory walked one entry per cycle. Add, cancel-all, finish
// and rejected or empty operations need no pass over the table. Cancel by id
// makes one compaction pass over the table. Extract makes a search pass for
// the best priority and then a compaction pass. The input is ready only while
// the sequencer is idle; a finished result sits in the output register, so a
// new word is accepted while it waits to be taken.
`default_nettype none
`include "assert_macros.svh"

module priority_task_queue_with_cancel
    import ptq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int ID_BITS       = 16,
    parameter int PRIORITY_BITS = 8,
    localparam int IN_W  = ((ID_BITS + PRIORITY_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((ID_BITS + PRIORITY_BITS + 1 + 2 * CNT_OUT_W + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // input channel
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [IN_W-1:0]  i_s_tdata,   // task_id, task_priority, zero pad
    input  wire logic [2:0]       i_s_tuser,   // func
    // result channel
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [OUT_W-1:0]      o_m_tdata,   // chosen_id, chosen_priority,
                                               // stop_current, removed_count,
                                               // queue_size, zero pad
    output logic [2:0]            o_m_tuser    // status, task_valid
);

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = ID_BITS + PRIORITY_BITS;

    // input field split
    logic [ID_BITS-1:0]       w_in_id;
    logic [PRIORITY_BITS-1:0] w_in_pri;
    t_func                    w_in_func;
    logic                     w_accept;

    assign w_in_id   = i_s_tdata[ID_BITS-1:0];
    assign w_in_pri  = i_s_tdata[ENT_W-1:ID_BITS];
    assign w_in_func = t_func'(i_s_tuser);
    assign w_accept  = i_s_tvalid && o_s_tready;

    // control state
    t_state             r_state, n_state;
    t_func              r_func;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_wr_ptr;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_idx;
    logic               r_cur_valid;
    logic [ID_BITS-1:0] r_cur_id;

    // working result
    t_status                  r_status;
    logic                     r_stop;
    logic                     r_tvalid;
    logic [CNT_W-1:0]         r_removed;
    logic [ID_BITS-1:0]       r_id;
    logic [AW-1:0]            r_best_idx;
    logic [ID_BITS-1:0]       r_best_id;
    logic [PRIORITY_BITS-1:0] r_best_pri;

    // output register
    logic                     r_o_valid;
    t_status                  r_o_status;
    logic                     r_o_tvalid;
    logic [ID_BITS-1:0]       r_o_id;
    logic [PRIORITY_BITS-1:0] r_o_pri;
    logic                     r_o_stop;
    logic [CNT_OUT_W-1:0]     r_o_removed;
    logic [CNT_OUT_W-1:0]     r_o_qsize;

    // pending table
    logic [ENT_W-1:0]         r_mem [QUEUE_DEPTH];
    logic [ENT_W-1:0]         r_rd_data;
    logic [ID_BITS-1:0]       w_rd_id;
    logic [PRIORITY_BITS-1:0] w_rd_pri;

    // sequencer controls
    logic             w_scanning;
    logic             w_rd_issue;
    logic             w_scan_end;
    logic             w_drop;
    logic             w_better;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic [ENT_W-1:0] w_wr_data;
    logic             w_out_free;

    assign w_rd_id  = r_rd_data[ID_BITS-1:0];
    assign w_rd_pri = r_rd_data[ENT_W-1:ID_BITS];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DONE;
                    if (w_in_func == FN_CANCEL && w_in_id != '0) begin
                        n_state = S_PACK;
                    end else if (w_in_func == FN_EXTRACT && r_cnt != '0) begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                if (w_scan_end) n_state = S_PACK;
            end
            S_PACK: begin
                if (w_scan_end) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs and table write port
    always_comb begin
        w_scanning = (r_state == S_FIND) || (r_state == S_PACK);
        w_rd_issue = w_scanning && (r_rd_ptr != r_cnt);
        w_scan_end = w_scanning && (r_rd_ptr == r_cnt) && !r_rd_vld;
        w_better   = (r_rd_idx == '0) || (w_rd_pri > r_best_pri);
        w_drop     = (r_func == FN_CANCEL) ? (w_rd_id == r_id) : (r_rd_idx == r_best_idx);
        w_out_free = !r_o_valid || i_m_tready;
        o_s_tready = (r_state == S_IDLE);
        w_wr_en    = 1'b0;
        w_wr_addr  = r_wr_ptr[AW-1:0];
        w_wr_data  = r_rd_data;
        if (r_state == S_IDLE) begin
            w_wr_en   = w_accept && (w_in_func == FN_ADD) && (r_cnt != CNT_W'(QUEUE_DEPTH));
            w_wr_addr = r_cnt[AW-1:0];
            w_wr_data = {w_in_pri, w_in_id};
        end else if (r_state == S_PACK) begin
            w_wr_en = r_rd_vld && !w_drop;
        end
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
        if (w_rd_issue) r_rd_data <= r_mem[r_rd_ptr[AW-1:0]];
    end

    // sequencer and table bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_cur_valid <= 1'b0;
            r_cur_id    <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func    <= w_in_func;
                        r_id      <= w_in_id;
                        r_rd_ptr  <= '0;
                        r_wr_ptr  <= '0;
                        r_rd_vld  <= 1'b0;
                        r_removed <= '0;
                        r_status  <= STS_OK;
                        r_stop    <= 1'b0;
                        r_tvalid  <= 1'b0;
                        unique case (w_in_func)
                            FN_ADD: begin
                                if (r_cnt == CNT_W'(QUEUE_DEPTH)) r_status <= STS_FULL;
                                else r_cnt <= r_cnt + 1'b1;
                            end
                            FN_CANCEL: begin
                                if (w_in_id == '0) r_status <= STS_ZERO_ID;
                                else r_stop <= r_cur_valid && (r_cur_id == w_in_id);
                            end
                            FN_CANCEL_ALL: begin
                                r_stop    <= r_cur_valid;
                                r_removed <= r_cnt;
                                r_cnt     <= '0;
                            end
                            FN_EXTRACT: begin
                                if (r_cnt == '0) begin
                                    r_status    <= STS_EMPTY;
                                    r_cur_valid <= 1'b0;
                                    r_cur_id    <= '0;
                                end
                            end
                            FN_FINISH: begin
                                r_cur_valid <= 1'b0;
                                r_cur_id    <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FIND: begin
                    // search pass: keep the earliest entry of the largest priority
                    r_rd_vld <= w_rd_issue;
                    r_rd_idx <= r_rd_ptr[AW-1:0];
                    if (w_rd_issue) r_rd_ptr <= r_rd_ptr + 1'b1;
                    if (r_rd_vld && w_better) begin
                        r_best_idx <= r_rd_idx;
                        r_best_id  <= w_rd_id;
                        r_best_pri <= w_rd_pri;
                    end
                    if (w_scan_end) r_rd_ptr <= '0;
                end
                S_PACK: begin
                    // compaction pass: drop matching entries, close the gaps
                    r_rd_vld <= w_rd_issue;
                    r_rd_idx <= r_rd_ptr[AW-1:0];
                    if (w_rd_issue) r_rd_ptr <= r_rd_ptr + 1'b1;
                    if (r_rd_vld) begin
                        if (!w_drop) r_wr_ptr <= r_wr_ptr + 1'b1;
                        else if (r_func == FN_CANCEL) r_removed <= r_removed + 1'b1;
                    end
                    if (w_scan_end) begin
                        r_cnt <= r_wr_ptr;
                        if (r_func == FN_EXTRACT) begin
                            r_tvalid    <= 1'b1;
                            r_cur_valid <= 1'b1;
                            r_cur_id    <= r_best_id;
                        end
                    end
                end
                S_DONE: ;
                default: ;
            endcase

            // output register
            if (r_state == S_DONE && w_out_free) begin
                r_o_valid   <= 1'b1;
                r_o_status  <= r_status;
                r_o_tvalid  <= r_tvalid;
                r_o_id      <= r_tvalid ? r_best_id : '0;
                r_o_pri     <= r_tvalid ? r_best_pri : '0;
                r_o_stop    <= r_stop;
                r_o_removed <= CNT_OUT_W'(r_removed);
                r_o_qsize   <= CNT_OUT_W'((CNT_W + 1)'(r_cnt) + (CNT_W + 1)'(r_cur_valid));
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // result word packing
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = OUT_W'({r_o_qsize, r_o_removed, r_o_stop, r_o_pri, r_o_id});
    assign o_m_tuser  = {r_o_tvalid, r_o_status};

    // checks
    `ASSERT_CLK(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(QUEUE_DEPTH), "pending count above depth")
    `ASSERT_IMPL(a_pack_order, i_clk, i_rst_n, (r_state == S_PACK) && r_rd_vld, CNT_W'(r_rd_idx) >= r_wr_ptr, "compaction write overtook read")
    `ASSERT_IMPL(a_idle_quiet, i_clk, i_rst_n, r_state == S_IDLE, !r_rd_vld, "read data pending in idle")
    `ASSERT_IMPL(a_task_ok, i_clk, i_rst_n, r_o_valid && r_o_tvalid, r_o_status == STS_OK, "returned task without ok status")

endmodule

`default_nettype wire
